FILE: sv/imadec_pkg.sv
package imadec_pkg;

  localparam int MAX_CHANNELS = 2;
  localparam int FRAME_DEPTH = 8 * MAX_CHANNELS;
  localparam int FRAME_AW = $clog2(FRAME_DEPTH);
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [6:0] STEP_MAX = 7'd88;

  typedef enum logic [1:0] {
    CFG_CHANNELS          = 2'd0,
    CFG_BLOCK_ALIGN       = 2'd1,
    CFG_SAMPLES_PER_BLOCK = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_DEC_LO,
    S_DEC_HI,
    S_EMIT
  } fsm_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_data;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic               last_of_run;
  } out_item_t;

  function automatic logic signed [4:0] index_adjust(input logic [3:0] nib);
    logic signed [4:0] adj;
    case (nib[2:0])
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0: s = 15'd7;       7'd1: s = 15'd8;       7'd2: s = 15'd9;
      7'd3: s = 15'd10;      7'd4: s = 15'd11;      7'd5: s = 15'd12;
      7'd6: s = 15'd13;      7'd7: s = 15'd14;      7'd8: s = 15'd16;
      7'd9: s = 15'd17;      7'd10: s = 15'd19;     7'd11: s = 15'd21;
      7'd12: s = 15'd23;     7'd13: s = 15'd25;     7'd14: s = 15'd28;
      7'd15: s = 15'd31;     7'd16: s = 15'd34;     7'd17: s = 15'd37;
      7'd18: s = 15'd41;     7'd19: s = 15'd45;     7'd20: s = 15'd50;
      7'd21: s = 15'd55;     7'd22: s = 15'd60;     7'd23: s = 15'd66;
      7'd24: s = 15'd73;     7'd25: s = 15'd80;     7'd26: s = 15'd88;
      7'd27: s = 15'd97;     7'd28: s = 15'd107;    7'd29: s = 15'd118;
      7'd30: s = 15'd130;    7'd31: s = 15'd143;    7'd32: s = 15'd157;
      7'd33: s = 15'd173;    7'd34: s = 15'd190;    7'd35: s = 15'd209;
      7'd36: s = 15'd230;    7'd37: s = 15'd253;    7'd38: s = 15'd279;
      7'd39: s = 15'd307;    7'd40: s = 15'd337;    7'd41: s = 15'd371;
      7'd42: s = 15'd408;    7'd43: s = 15'd449;    7'd44: s = 15'd494;
      7'd45: s = 15'd544;    7'd46: s = 15'd598;    7'd47: s = 15'd658;
      7'd48: s = 15'd724;    7'd49: s = 15'd796;    7'd50: s = 15'd876;
      7'd51: s = 15'd963;    7'd52: s = 15'd1060;   7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;   7'd55: s = 15'd1411;   7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;   7'd58: s = 15'd1878;   7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;   7'd61: s = 15'd2499;   7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;   7'd64: s = 15'd3327;   7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;   7'd67: s = 15'd4428;   7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;   7'd70: s = 15'd5894;   7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;   7'd73: s = 15'd7845;   7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;   7'd76: s = 15'd10442;  7'd77: s = 15'd11487;
      7'd78: s = 15'd12635;  7'd79: s = 15'd13899;  7'd80: s = 15'd15289;
      7'd81: s = 15'd16818;  7'd82: s = 15'd18500;  7'd83: s = 15'd20350;
      7'd84: s = 15'd22385;  7'd85: s = 15'd24623;  7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;  7'd88: s = 15'd32767;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/ima_adpcm_block_decoder.sv
// Header bytes other than the last one per block are absorbed without leaving the idle state.
// A data byte passes the transfer, then goes one nibble per cycle through the decoder (S_DEC_LO, then S_DEC_HI).
// A byte that closes a group leads to S_EMIT, which reads the samples out of the
// frame memory (up to 8 or 16 samples); the last header byte leads to S_HDR, which emits each channel's predictor.
// Synchronous active-high reset restores the default configuration and clears
// the position, predictors and step indexes; the frame memory is not cleared.
module ima_adpcm_block_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  imadec_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output imadec_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  imadec_pkg::fsm_state_t state, state_next;

  logic [1:0]  chans;
  logic [15:0] align;
  logic [15:0] spb;
  logic [15:0] byte_pos;
  logic [15:0] samples_emitted;
  logic [15:0] predictor [imadec_pkg::MAX_CHANNELS];
  logic [6:0]  step_index [imadec_pkg::MAX_CHANNELS];

  logic [7:0]  cur_byte;
  logic [imadec_pkg::CH_W-1:0] dch;
  logic [1:0]  dsub;
  logic        group_end;
  logic [imadec_pkg::CH_W-1:0] hdr_cnt;
  logic [imadec_pkg::FRAME_AW-1:0] emit_k;
  logic        rd_pending;

  logic [15:0] fstore [imadec_pkg::FRAME_DEPTH];
  logic [15:0] fs_rdata;
  logic        fs_we, fs_re;
  logic [imadec_pkg::FRAME_AW-1:0] fs_waddr, fs_raddr;

  // Input decode at acceptance.
  logic        in_accept;
  logic [15:0] pos;
  logic [16:0] pos_inc;
  logic [15:0] pos_next;
  logic [3:0]  hdr_len;
  logic [2:0]  grp_mask;
  logic [2:0]  grp_off;
  logic [15:0] grp_start;
  logic        cfg_ok, is_hdr, fits, below;
  logic        acc_hdr, acc_hdr_last, acc_data;
  logic        stereo;

  always_comb begin
    stereo    = (chans == 2'd2);
    in_accept = in_valid && !in_stall;
    pos       = in_data.start_of_data ? 16'd0 : byte_pos;
    pos_inc   = {1'b0, pos} + 17'd1;
    pos_next  = (pos_inc >= {1'b0, align}) ? 16'd0 : pos_inc[15:0];
    hdr_len   = stereo ? 4'd8 : 4'd4;
    grp_mask  = stereo ? 3'd7 : 3'd3;
    grp_off   = pos[2:0] & grp_mask;
    grp_start = {pos[15:3], pos[2:0] & ~grp_mask};
    cfg_ok    = ((chans == 2'd1) || stereo) && (align >= {12'd0, hdr_len});
    is_hdr    = (pos < {12'd0, hdr_len});
    fits      = ({1'b0, grp_start} + {13'd0, hdr_len}) <= {1'b0, align};
    below     = (spb == 16'd0) || (samples_emitted < spb);
    acc_hdr      = in_accept && cfg_ok && is_hdr;
    acc_hdr_last = acc_hdr && (pos[3:0] == (hdr_len - 4'd1));
    acc_data     = in_accept && cfg_ok && !is_hdr && fits && below;
  end

  // Shared nibble decode unit.
  logic [3:0]  nib;
  logic [imadec_pkg::CH_W-1:0] pred_sel;
  logic [15:0] pred_rd;
  logic [6:0]  si;
  logic [14:0] step;
  logic [16:0] diff;
  logic signed [17:0] pext, dext, vsum;
  logic [15:0] pred_new;
  logic signed [8:0] ni;
  logic [6:0]  si_new;

  always_comb begin
    nib      = (state == imadec_pkg::S_DEC_HI) ? cur_byte[7:4] : cur_byte[3:0];
    pred_sel = (state == imadec_pkg::S_HDR) ? hdr_cnt : dch;
    pred_rd  = predictor[pred_sel];
    si       = step_index[dch];
    step     = imadec_pkg::step_size(si);
    diff     = {5'd0, step[14:3]}
             + (nib[2] ? {2'd0, step} : 17'd0)
             + (nib[1] ? {3'd0, step[14:1]} : 17'd0)
             + (nib[0] ? {4'd0, step[14:2]} : 17'd0);
    pext     = signed'({{2{pred_rd[15]}}, pred_rd});
    dext     = signed'({1'b0, diff});
    vsum     = nib[3] ? (pext - dext) : (pext + dext);
    if (vsum > 18'sd32767) begin
      pred_new = 16'h7FFF;
    end else if (vsum < -18'sd32768) begin
      pred_new = 16'h8000;
    end else begin
      pred_new = vsum[15:0];
    end
    ni = signed'({2'd0, si}) + 9'(imadec_pkg::index_adjust(nib));
    if (ni < 9'sd0) begin
      si_new = 7'd0;
    end else if (ni > 9'sd88) begin
      si_new = imadec_pkg::STEP_MAX;
    end else begin
      si_new = ni[6:0];
    end
  end

  // Readout control.
  logic        out_free;
  logic        hdr_load, hdr_last;
  logic        emit_load, emit_last, frame_end;
  logic [2:0]  emit_s;
  logic        emit_c;
  logic [15:0] se_inc;
  logic        below_after;
  logic        dec_active;

  always_comb begin
    out_free    = !out_valid || !out_stall;
    hdr_last    = (hdr_cnt == imadec_pkg::CH_W'(stereo));
    hdr_load    = (state == imadec_pkg::S_HDR) && out_free;
    emit_s      = stereo ? emit_k[3:1] : emit_k[2:0];
    emit_c      = stereo ? emit_k[0] : 1'b0;
    frame_end   = !stereo || emit_k[0];
    se_inc      = (samples_emitted == 16'hFFFF) ? samples_emitted : samples_emitted + 16'd1;
    below_after = (spb == 16'd0) || (se_inc < spb);
    emit_last   = frame_end && ((emit_s == 3'd7) || !below_after);
    emit_load   = (state == imadec_pkg::S_EMIT) && rd_pending && out_free;
    fs_re       = (state == imadec_pkg::S_EMIT) && (!rd_pending || (emit_load && !emit_last));
    fs_raddr    = rd_pending ? emit_k + 1'b1 : emit_k;
    dec_active  = (state == imadec_pkg::S_DEC_LO) || (state == imadec_pkg::S_DEC_HI);
    fs_we       = dec_active;
    fs_waddr    = stereo ? {dsub, (state == imadec_pkg::S_DEC_HI), dch}
                         : {1'b0, dsub, (state == imadec_pkg::S_DEC_HI)};
    in_stall    = (state != imadec_pkg::S_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      imadec_pkg::S_IDLE: begin
        if (acc_hdr_last) begin
          state_next = imadec_pkg::S_HDR;
        end else if (acc_data) begin
          state_next = imadec_pkg::S_DEC_LO;
        end
      end
      imadec_pkg::S_HDR: begin
        if (hdr_load && hdr_last) begin
          state_next = imadec_pkg::S_IDLE;
        end
      end
      imadec_pkg::S_DEC_LO: state_next = imadec_pkg::S_DEC_HI;
      imadec_pkg::S_DEC_HI: begin
        state_next = group_end ? imadec_pkg::S_EMIT : imadec_pkg::S_IDLE;
      end
      imadec_pkg::S_EMIT: begin
        if (emit_load && emit_last) begin
          state_next = imadec_pkg::S_IDLE;
        end
      end
      default: state_next = imadec_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fstore[fs_waddr] <= pred_new;
    end
    if (fs_re) begin
      fs_rdata <= fstore[fs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_byte  <= in_data.data_byte;
      dch       <= stereo ? grp_off[2] : 1'b0;
      dsub      <= grp_off[1:0];
      group_end <= ({1'b0, grp_off} == (hdr_len - 4'd1));
    end
    if (hdr_load || emit_load) begin
      out_data.sample      <= hdr_load ? pred_rd : fs_rdata;
      out_data.channel     <= hdr_load ? hdr_cnt : emit_c;
      out_data.last_of_run <= hdr_load ? hdr_last : emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= imadec_pkg::S_IDLE;
      chans           <= 2'd1;
      align           <= 16'd256;
      spb             <= 16'd0;
      byte_pos        <= 16'd0;
      samples_emitted <= 16'd0;
      for (int c = 0; c < imadec_pkg::MAX_CHANNELS; c++) begin
        predictor[c]  <= 16'd0;
        step_index[c] <= 7'd0;
      end
      hdr_cnt    <= '0;
      emit_k     <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          imadec_pkg::CFG_CHANNELS:          chans <= cfg_data[1:0];
          imadec_pkg::CFG_BLOCK_ALIGN:       align <= cfg_data;
          imadec_pkg::CFG_SAMPLES_PER_BLOCK: spb   <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        byte_pos <= pos_next;
      end
      if (acc_hdr) begin
        case (pos[1:0])
          2'd0: predictor[pos[2]][7:0]  <= in_data.data_byte;
          2'd1: predictor[pos[2]][15:8] <= in_data.data_byte;
          2'd2: step_index[pos[2]] <= (in_data.data_byte > 8'd88) ? imadec_pkg::STEP_MAX
                                                                  : in_data.data_byte[6:0];
          default: ;
        endcase
      end
      if (dec_active) begin
        predictor[dch]  <= pred_new;
        step_index[dch] <= si_new;
      end
      if (acc_hdr_last) begin
        hdr_cnt <= '0;
      end else if (hdr_load && !hdr_last) begin
        hdr_cnt <= hdr_cnt + 1'b1;
      end
      if (state == imadec_pkg::S_DEC_HI) begin
        emit_k <= '0;
      end else if (emit_load && !emit_last) begin
        emit_k <= emit_k + 1'b1;
      end
      if (fs_re) begin
        rd_pending <= 1'b1;
      end else if (emit_load) begin
        rd_pending <= 1'b0;
      end
      if (hdr_load && hdr_last) begin
        samples_emitted <= 16'd1;
      end else if (emit_load && frame_end) begin
        samples_emitted <= se_inc;
      end
      if (hdr_load || emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_dec_pair: assert property (@(posedge clk) disable iff (rst)
    state == imadec_pkg::S_DEC_LO |=> state == imadec_pkg::S_DEC_HI)
    else $error("low nibble decode not followed by high nibble decode");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_index[0] <= imadec_pkg::STEP_MAX && step_index[1] <= imadec_pkg::STEP_MAX)
    else $error("step index out of range");

  a_mono_frames: assert property (@(posedge clk) disable iff (rst)
    state == imadec_pkg::S_EMIT && chans == 2'd1 |-> !emit_k[3])
    else $error("mono readout beyond eight frames");

  a_emit_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == imadec_pkg::S_EMIT) |-> !rd_pending && emit_k == '0)
    else $error("readout started with stale read state");

endmodule
